// ===== sv/tsi_pkg.sv =====
// ----------------------------------------------------------------------------
// tsi_pkg
// shared types and constants of the timestamped sample interpolator
// ----------------------------------------------------------------------------
`default_nettype none

package tsi_pkg;

  // fixed field widths of the channels
  localparam int TIME_W = 48;
  localparam int SMP_W  = 8;
  localparam int VOL_W  = 7;
  localparam int OUT_W  = 14;
  localparam int MODE_W = 2;
  localparam int MAG_W  = 14;   // magnitude of a sample difference

  localparam logic [VOL_W-1:0] VOL_MAX = 7'd64;

  // operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  // interpolation mode codes
  localparam logic [MODE_W-1:0] MODE_HOLD    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_NEAREST = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LINEAR  = 2'd2;

  // result source
  typedef enum logic [1:0] {
    RES_S1  = 2'd0,
    RES_S2  = 2'd1,
    RES_LIN = 2'd2
  } res_sel_t;

  // controller to datapath
  typedef struct packed {
    logic     init_wr;
    logic     insert;
    logic     capture;
    logic     rd_next;
    logic     advance;
    logic     save_c2;
    logic     save_c1;
    logic     set_res;
    res_sel_t res_sel;
    logic     div_start;
    logic     load_out;
  } tsi_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic ge2;
    logic key_le_t;
    logic early;
    logic near_s1;
    logic div_done;
    logic out_free;
  } tsi_stat_t;

endpackage

`default_nettype wire

// ===== sv/tsi_if.sv =====
// ----------------------------------------------------------------------------
// tsi channel interfaces
// valid/ready channels for input items, results and the mode register
// ----------------------------------------------------------------------------
`default_nettype none

interface tsi_in_if
  import tsi_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic                    operation;
  logic [TIME_W-1:0]       time_req;
  logic signed [SMP_W-1:0] sample_byte;
  logic [VOL_W-1:0]        volume;

  modport source (output valid, operation, time_req, sample_byte, volume, input ready);
  modport sink   (input valid, operation, time_req, sample_byte, volume, output ready);
endinterface

interface tsi_out_if
  import tsi_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] sample_out;

  modport source (output valid, sample_out, input ready);
  modport sink   (input valid, sample_out, output ready);
endinterface

interface tsi_cfg_if
  import tsi_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] interp_mode;

  modport source (output valid, interp_mode, input ready);
  modport sink   (input valid, interp_mode, output ready);
endinterface

`default_nettype wire

// ===== sv/tsi_div.sv =====
// ----------------------------------------------------------------------------
// tsi_div
// shift-add divider: floor(e * m / dx) and remainder flag, a doubling and an add phase per bit
// ----------------------------------------------------------------------------
`default_nettype none

module tsi_div
  import tsi_pkg::*;
#(
  parameter int TIME_BITS = 48
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [TIME_BITS-1:0] e,
  input  wire logic [TIME_BITS-1:0] dx,
  input  wire logic [MAG_W-1:0]     m,
  output logic                      done,
  output logic [MAG_W-1:0]          quot,
  output logic                      rem_nz
);

  localparam int CW = $clog2(MAG_W);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic                 phase_r, phase_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [TIME_BITS:0]   rem_r, rem_nxt;
  logic [TIME_BITS-1:0] e_r, dx_r;
  logic [MAG_W-1:0]     m_r, m_nxt;
  logic [MAG_W-1:0]     q_r, q_nxt;
  logic [TIME_BITS:0]   cand;
  logic                 ge;

  always_comb begin
    // phase 0 doubles the partial remainder, phase 1 adds e for a set bit
    if (phase_r) begin
      cand = rem_r + (m_r[MAG_W-1] ? {1'b0, e_r} : '0);
    end else begin
      cand = {rem_r[TIME_BITS-1:0], 1'b0};
    end
    ge = (cand >= {1'b0, dx_r});
    rem_nxt = ge ? (cand - {1'b0, dx_r}) : cand;
    q_nxt = phase_r ? (q_r + MAG_W'(ge)) : {q_r[MAG_W-2:0], ge};
    m_nxt = phase_r ? {m_r[MAG_W-2:0], 1'b0} : m_r;
    cnt_nxt = phase_r ? (cnt_r - CW'(1)) : cnt_r;
    phase_nxt = ~phase_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (phase_r && (cnt_r == '0)) begin
      busy_nxt = 1'b0;
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r) begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      e_r     <= e;
      dx_r    <= dx;
      m_r     <= m;
      rem_r   <= '0;
      q_r     <= '0;
      phase_r <= 1'b0;
      cnt_r   <= CW'(MAG_W - 1);
    end else if (busy_r) begin
      rem_r   <= rem_nxt;
      q_r     <= q_nxt;
      m_r     <= m_nxt;
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign done   = done_r;
  assign quot   = q_r;
  assign rem_nz = (rem_r != '0);

  // partial remainder stays reduced below the divisor
  a_rem_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !$past(start) |-> rem_r < {1'b0, dx_r})
    else $error("divider remainder not reduced");

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("divider done without a run");

endmodule

`default_nettype wire

// ===== sv/tsi_datapath.sv =====
// ----------------------------------------------------------------------------
// tsi_datapath
// sample store, pointers, query registers, divider and output register
// ----------------------------------------------------------------------------
`default_nettype none

module tsi_datapath
  import tsi_pkg::*;
#(
  parameter int DEPTH     = 256,
  parameter int TIME_BITS = 48
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire tsi_cmd_t                cmd,
  output tsi_stat_t                    stat,
  input  wire logic [TIME_W-1:0]       in_time_req,
  input  wire logic signed [SMP_W-1:0] in_sample_byte,
  input  wire logic [VOL_W-1:0]        in_volume,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic signed [OUT_W-1:0]      out_sample
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  // store
  logic [TIME_BITS-1:0] key_mem [DEPTH];
  logic [OUT_W-1:0]     val_mem [DEPTH];
  logic [TIME_BITS-1:0] rd_key_r;
  logic [OUT_W-1:0]     rd_val_r;

  logic [PTR_W-1:0] rp_r, wp_r;
  logic [CNT_W-1:0] cnt_r;
  logic [PTR_W-1:0] rp_inc, wp_inc, rd_addr, wr_addr;
  logic             full, we;

  logic [TIME_BITS-1:0]    t_in, t_r, c2_r, e_r, dx_r;
  logic signed [OUT_W-1:0] s1_r, s2_r, res_r, s_ins, lin_res;
  logic [VOL_W-1:0]        vol_sat;
  logic signed [OUT_W:0]   prod, dy;
  logic [MAG_W-1:0]        mag;
  logic                    early_r, dy_neg_r;
  logic signed [OUT_W+1:0] base, base_adj;
  logic                    div_done, rem_nz;
  logic [MAG_W-1:0]        quot;
  logic                    out_valid_r;
  logic signed [OUT_W-1:0] out_sample_r;

  assign rp_inc = (rp_r == PTR_W'(DEPTH - 1)) ? '0 : rp_r + PTR_W'(1);
  assign wp_inc = (wp_r == PTR_W'(DEPTH - 1)) ? '0 : wp_r + PTR_W'(1);
  assign full   = (cnt_r == CNT_W'(DEPTH));
  assign t_in   = TIME_BITS'(in_time_req);

  // insert scaling, volume saturates at full scale
  assign vol_sat = (in_volume > VOL_MAX) ? VOL_MAX : in_volume;
  assign prod    = $signed({{(OUT_W + 1 - SMP_W){in_sample_byte[SMP_W-1]}}, in_sample_byte})
                 * $signed({{(OUT_W + 1 - VOL_W){1'b0}}, vol_sat});
  assign s_ins   = prod[OUT_W-1:0];

  assign we      = cmd.init_wr || (cmd.insert && !full);
  assign wr_addr = cmd.init_wr ? '0 : wp_r;
  assign rd_addr = cmd.rd_next ? rp_inc : rp_r;

  always_ff @(posedge clk) begin
    if (we) begin
      key_mem[wr_addr] <= cmd.init_wr ? '0 : t_in;
      val_mem[wr_addr] <= cmd.init_wr ? '0 : s_ins;
    end
    rd_key_r <= key_mem[rd_addr];
    rd_val_r <= val_mem[rd_addr];
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rp_r  <= '0;
      wp_r  <= PTR_W'(1);
      cnt_r <= CNT_W'(1);
    end else if (cmd.insert && !full) begin
      wp_r  <= wp_inc;
      cnt_r <= cnt_r + CNT_W'(1);
    end else if (cmd.advance) begin
      rp_r  <= rp_inc;
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  // query registers
  assign dy  = $signed({s2_r[OUT_W-1], s2_r}) - $signed({s1_r[OUT_W-1], s1_r});
  assign mag = dy[OUT_W] ? MAG_W'(-dy) : MAG_W'(dy);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      t_r <= t_in;
    end
    if (cmd.save_c2) begin
      c2_r <= rd_key_r;
      s2_r <= rd_val_r;
    end
    if (cmd.save_c1) begin
      s1_r    <= rd_val_r;
      e_r     <= t_r - rd_key_r;
      dx_r    <= c2_r - rd_key_r;
      early_r <= (t_r < rd_key_r);
    end
    if (cmd.div_start) begin
      dy_neg_r <= dy[OUT_W];
    end
  end

  tsi_div #(
    .TIME_BITS(TIME_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .e     (e_r),
    .dx    (dx_r),
    .m     (mag),
    .done  (div_done),
    .quot  (quot),
    .rem_nz(rem_nz)
  );

  // linear result, truncated toward zero
  always_comb begin
    base = dy_neg_r ? ($signed({{2{s1_r[OUT_W-1]}}, s1_r}) - $signed({2'b00, quot}))
                    : ($signed({{2{s1_r[OUT_W-1]}}, s1_r}) + $signed({2'b00, quot}));
    base_adj = base;
    if (rem_nz && !dy_neg_r && (base < 0)) begin
      base_adj = base + 16'sd1;
    end else if (rem_nz && dy_neg_r && (base > 0)) begin
      base_adj = base - 16'sd1;
    end
    lin_res = base_adj[OUT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.set_res) begin
      case (cmd.res_sel)
        RES_S2:  res_r <= s2_r;
        RES_LIN: res_r <= lin_res;
        default: res_r <= s1_r;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_sample_r <= res_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;

  assign stat.ge2      = (cnt_r >= CNT_W'(2));
  assign stat.key_le_t = (rd_key_r <= t_r);
  assign stat.early    = early_r;
  assign stat.near_s1  = ({e_r, 1'b0} < {1'b0, dx_r});
  assign stat.div_done = div_done;
  assign stat.out_free = !out_valid_r || out_ready;

  // pointer bookkeeping check
  logic [CNT_W:0] chk_sum, chk_wrap;
  assign chk_sum  = (CNT_W + 1)'(rp_r) + (CNT_W + 1)'(cnt_r);
  assign chk_wrap = (chk_sum >= (CNT_W + 1)'(DEPTH)) ? chk_sum - (CNT_W + 1)'(DEPTH) : chk_sum;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r >= CNT_W'(1)) && (cnt_r <= CNT_W'(DEPTH)))
    else $error("entry count out of range");

  a_ptr_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    chk_wrap == (CNT_W + 1)'(wp_r))
    else $error("write pointer does not match read pointer plus count");

  a_load_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("result loaded over a pending beat");

endmodule

`default_nettype wire

// ===== sv/tsi_ctrl.sv =====
// ----------------------------------------------------------------------------
// tsi_ctrl
// sequencer for insert and query, holds the interpolation mode register
// ----------------------------------------------------------------------------
`default_nettype none

module tsi_ctrl
  import tsi_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_operation,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [MODE_W-1:0] cfg_mode,
  input  wire tsi_stat_t         stat,
  output tsi_cmd_t               cmd
);

  typedef enum logic [7:0] {
    S_INIT     = 8'b0000_0001,
    S_IDLE     = 8'b0000_0010,
    S_WALK_RD  = 8'b0000_0100,
    S_WALK_CHK = 8'b0000_1000,
    S_CUR      = 8'b0001_0000,
    S_DECIDE   = 8'b0010_0000,
    S_DIV      = 8'b0100_0000,
    S_OUT      = 8'b1000_0000
  } state_t;

  state_t            state_r, state_nxt;
  logic [MODE_W-1:0] mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_HOLD;
    end else if (cfg_valid) begin
      mode_r <= cfg_mode;
    end
  end

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_INIT: begin
        cmd.init_wr = 1'b1;
        state_nxt   = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          if (in_operation == OP_INSERT) begin
            cmd.insert = 1'b1;
          end else begin
            cmd.capture = 1'b1;
            state_nxt   = S_WALK_RD;
          end
        end
      end
      S_WALK_RD: begin
        // look at the next key while two or more entries remain
        if (stat.ge2) begin
          cmd.rd_next = 1'b1;
          state_nxt   = S_WALK_CHK;
        end else begin
          state_nxt = S_CUR;
        end
      end
      S_WALK_CHK: begin
        if (stat.key_le_t) begin
          cmd.advance = 1'b1;
          state_nxt   = S_WALK_RD;
        end else begin
          cmd.save_c2 = 1'b1;
          state_nxt   = S_CUR;
        end
      end
      S_CUR: begin
        cmd.save_c1 = 1'b1;
        state_nxt   = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.res_sel = RES_S1;
        if (!stat.ge2 || stat.early) begin
          cmd.set_res = 1'b1;
          state_nxt   = S_OUT;
        end else begin
          case (mode_r)
            MODE_NEAREST: begin
              cmd.set_res = 1'b1;
              cmd.res_sel = stat.near_s1 ? RES_S1 : RES_S2;
              state_nxt   = S_OUT;
            end
            MODE_LINEAR: begin
              cmd.div_start = 1'b1;
              state_nxt     = S_DIV;
            end
            default: begin
              cmd.set_res = 1'b1;
              state_nxt   = S_OUT;
            end
          endcase
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          cmd.set_res = 1'b1;
          cmd.res_sel = RES_LIN;
          state_nxt   = S_OUT;
        end
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/timestamped_sample_interpolator_top.sv =====
// ----------------------------------------------------------------------------
// timestamped_sample_interpolator_top
// timestamped sample queue with hold, nearest and linear lookup at a time
// ----------------------------------------------------------------------------
// channels: in_if carries insert and query beats, out_if returns one sample
//   per query, cfg_if writes the interpolation mode (always ready)
// an insert beat keeps the sequencer in idle, so the block stays ready
// a query walks stale entries (S_WALK_RD then S_WALK_CHK per key read from
//   the store's read port), then runs S_CUR, S_DECIDE, in linear mode S_DIV
//   (a doubling and an add phase per bit of the 14-bit difference magnitude)
//   and S_OUT; in_if.ready stays low until the query leaves S_OUT
// a query result sits in the output register; the next beat is accepted
//   while it waits, and a following query stalls only at its own result
//   until the receiver drains the pending beat
// reset: the sequencer starts in S_INIT, which writes the dummy entry
//   (time 0, value 0) at slot 0; in_if.ready stays low while it does
// inserts into a full store are dropped, mode 3 behaves as hold
// ----------------------------------------------------------------------------
`default_nettype none

module timestamped_sample_interpolator_top
  import tsi_pkg::*;
#(
  parameter int DEPTH     = 256,
  parameter int TIME_BITS = 48
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  tsi_in_if.sink     in_if,
  tsi_out_if.source  out_if,
  tsi_cfg_if.sink    cfg_if
);

  // command and status between the sequencer and the datapath
  tsi_cmd_t  cmd;
  tsi_stat_t stat;

  // sequencer: accepts beats, walks stale entries, picks the result source
  tsi_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_if.valid),
    .in_ready    (in_if.ready),
    .in_operation(in_if.operation),
    .cfg_valid   (cfg_if.valid),
    .cfg_ready   (cfg_if.ready),
    .cfg_mode    (cfg_if.interp_mode),
    .stat        (stat),
    .cmd         (cmd)
  );

  // datapath: store memories, pointers, divider and output register
  tsi_datapath #(
    .DEPTH    (DEPTH),
    .TIME_BITS(TIME_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_time_req   (in_if.time_req),
    .in_sample_byte(in_if.sample_byte),
    .in_volume     (in_if.volume),
    .out_valid     (out_if.valid),
    .out_ready     (out_if.ready),
    .out_sample    (out_if.sample_out)
  );

endmodule

`default_nettype wire

// ===== sim/tsi_lookup_checker.sv =====
// ----------------------------------------------------------------------------
// tsi_lookup_checker
// watches the three channels of the sample interpolator, keeps its own copy
// of the timestamped store and compares every sample_out beat in order
// ----------------------------------------------------------------------------
module tsi_lookup_checker
  import tsi_pkg::*;
#(
  parameter int DEPTH = 256
) (
  input  logic clk,
  input  logic rst_n,
  tsi_in_if    in_mon,
  tsi_out_if   out_mon,
  tsi_cfg_if   cfg_mon,
  output int   mismatches,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [TIME_W-1:0]       key_mem [DEPTH];
  logic signed [OUT_W-1:0] val_mem [DEPTH];
  int                      head;
  int                      tail;
  int                      fill;
  logic [MODE_W-1:0]       mode;
  logic signed [OUT_W-1:0] expected_samples [$];
  logic signed [OUT_W-1:0] want;

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  function automatic int wrap_next(input int i);
    return (i + 1 == DEPTH) ? 0 : i + 1;
  endfunction

  // append a scaled sample, dropped when the store is full
  function automatic void store_sample(input logic [TIME_W-1:0] t,
                                       input logic signed [SMP_W-1:0] smp,
                                       input logic [VOL_W-1:0] vol);
    logic [VOL_W-1:0] v;
    v = (vol > VOL_MAX) ? VOL_MAX : vol;
    if (fill < DEPTH) begin
      key_mem[tail] = t;
      val_mem[tail] = OUT_W'(int'(smp) * int'(v));
      tail = wrap_next(tail);
      fill++;
    end
  endfunction

  // retire stale entries, then look up the value at time t
  function automatic logic signed [OUT_W-1:0] sample_at(input logic [TIME_W-1:0] t);
    logic [TIME_W-1:0]       c1;
    logic [TIME_W-1:0]       c2;
    logic signed [OUT_W-1:0] s1;
    logic signed [OUT_W-1:0] s2;
    longint                  span;
    longint                  num;
    int                      nxt;
    while (fill >= 2 && key_mem[wrap_next(head)] <= t) begin
      head = wrap_next(head);
      fill--;
    end
    s1 = val_mem[head];
    if (fill < 2) return s1;
    nxt = wrap_next(head);
    c1  = key_mem[head];
    c2  = key_mem[nxt];
    s2  = val_mem[nxt];
    if (t < c1) return s1;
    case (mode)
      MODE_NEAREST: return (t - c1 < c2 - t) ? s1 : s2;
      MODE_LINEAR: begin
        // exact line through both points, signed division truncates to zero
        span = longint'(c2 - c1);
        num  = longint'(s1) * span + longint'(t - c1) * longint'(int'(s2) - int'(s1));
        return OUT_W'(num / span);
      end
      default: return s1;
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      head       = 0;
      tail       = 1;
      fill       = 1;
      mode       = MODE_HOLD;
      key_mem[0] = '0;
      val_mem[0] = '0;
      expected_samples.delete();
      pending <= 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_samples.size() == 0) begin
          mismatches++;
          $display("%0t sample_out: expected none, actual %0d", $time, out_mon.sample_out);
        end else begin
          want = expected_samples.pop_front();
          if (out_mon.sample_out !== want) begin
            mismatches++;
            $display("%0t sample_out: expected %0d, actual %0d",
                     $time, want, out_mon.sample_out);
          end
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) mode = cfg_mon.interp_mode;
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.operation == OP_INSERT) begin
          store_sample(in_mon.time_req, in_mon.sample_byte, in_mon.volume);
        end else begin
          expected_samples.push_back(sample_at(in_mon.time_req));
        end
      end
      pending <= expected_samples.size();
    end
  end

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// stimulus for the timestamped sample interpolator: a directed walk through
// hold, nearest and linear lookups, then phases of random timestamp streams,
// store fills and noise under every mode, with bursty input and a stalling
// receiver; the checker beside the block predicts and compares
// ----------------------------------------------------------------------------
module tb
  import tsi_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int                STORE_DEPTH   = 256;
  localparam int                N_ITEMS       = 1750;
  localparam logic [MODE_W-1:0] MODE_ALT_HOLD = 2'd3;   // unused code, acts as hold
  localparam logic [TIME_W-1:0] T_MAX         = '1;

  logic clk = 1'b0;
  logic rst_n;

  tsi_in_if  in_b ();
  tsi_out_if out_b ();
  tsi_cfg_if cfg_b ();

  int mismatches;
  int pending;

  // stream bookkeeping for the generator
  int                burst_left;
  bit                steady;       // phase with no idling on either side
  int                items_sent;
  int                fills_done;
  logic [TIME_W-1:0] last_ins_t;
  logic [TIME_W-1:0] last_q_t;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  timestamped_sample_interpolator_top #(
    .DEPTH     (STORE_DEPTH),
    .TIME_BITS (TIME_W)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_b),
    .out_if (out_b),
    .cfg_if (cfg_b)
  );

  tsi_lookup_checker #(
    .DEPTH (STORE_DEPTH)
  ) u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_b),
    .out_mon    (out_b),
    .cfg_mon    (cfg_b),
    .mismatches (mismatches),
    .pending    (pending)
  );

  // ---- random helpers ------------------------------------------------------

  function automatic logic [TIME_W-1:0] rand_t();
    return TIME_W'({$urandom, $urandom});
  endfunction

  function automatic logic [TIME_W-1:0] rand_below(input logic [TIME_W-1:0] bound);
    return (bound == '0) ? '0 : rand_t() % bound;
  endfunction

  // mostly small steps so ties and equal keys show up, now and then huge ones
  function automatic logic [TIME_W-1:0] time_step();
    case ($urandom_range(0, 9))
      0:          return '0;
      1, 2:       return TIME_W'($urandom_range(1, 4));
      3, 4, 5, 6: return TIME_W'($urandom_range(5, 1000));
      7, 8:       return TIME_W'($urandom_range(1001, 1 << 20));
      default:    return rand_below(48'h100_0000_0000);
    endcase
  endfunction

  // volumes above full scale get saturated by the block
  function automatic logic [VOL_W-1:0] rand_volume();
    if ($urandom_range(0, 6) == 0) return VOL_W'($urandom_range(65, 127));
    return VOL_W'($urandom_range(0, 64));
  endfunction

  function automatic logic [MODE_W-1:0] mode_by_index(input int i);
    case (i)
      0:       return MODE_HOLD;
      1:       return MODE_NEAREST;
      2:       return MODE_LINEAR;
      default: return MODE_ALT_HOLD;
    endcase
  endfunction

  // ---- channel drivers -----------------------------------------------------

  // one beat on the input channel; the sender runs in bursts with gaps
  task automatic send_item(input logic op, input logic [TIME_W-1:0] t,
                           input logic signed [SMP_W-1:0] smp,
                           input logic [VOL_W-1:0] vol);
    int gap;
    if (!steady && burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_b.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_b.valid       <= 1'b1;
    in_b.operation   <= op;
    in_b.time_req    <= t;
    in_b.sample_byte <= smp;
    in_b.volume      <= vol;
    @(posedge clk);
    while (!in_b.ready) @(posedge clk);
    burst_left--;
    items_sent++;
  endtask

  task automatic insert_at(input logic [TIME_W-1:0] t,
                           input logic signed [SMP_W-1:0] smp,
                           input logic [VOL_W-1:0] vol);
    send_item(OP_INSERT, t, smp, vol);
  endtask

  // sample and volume carry junk on queries, the block must ignore them
  task automatic query_at(input logic [TIME_W-1:0] t);
    send_item(OP_QUERY, t, SMP_W'($urandom), VOL_W'($urandom));
  endtask

  // mode writes only with the block drained; inserts leave no result, so
  // give the block a query's worth of cycles before touching the register
  task automatic set_mode(input logic [MODE_W-1:0] m);
    in_b.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_b.valid       <= 1'b1;
    cfg_b.interp_mode <= m;
    @(posedge clk);
    while (!cfg_b.ready) @(posedge clk);
    cfg_b.valid <= 1'b0;
  endtask

  // ---- well-formed stream --------------------------------------------------

  // next insert keeps timestamps non-decreasing, restarting low near the top
  task automatic insert_next();
    logic [TIME_W-1:0] step;
    step = time_step();
    if (last_ins_t > T_MAX - step) begin
      last_ins_t = rand_below(1000);
      last_q_t   = '0;
    end else begin
      last_ins_t = last_ins_t + step;
    end
    insert_at(last_ins_t, SMP_W'($urandom), rand_volume());
  endtask

  // queries mostly trail the newest insert, sometimes land on it exactly
  task automatic query_next();
    logic [TIME_W-1:0] q;
    if ($urandom_range(0, 9) == 0) begin
      q = last_ins_t;
    end else if (last_ins_t > last_q_t) begin
      q = last_q_t + rand_below(((last_ins_t - last_q_t) >> $urandom_range(0, 3)) + 2);
    end else begin
      q = last_q_t + TIME_W'($urandom_range(0, 2));
    end
    last_q_t = q;
    query_at(q);
  endtask

  // ---- receiver ------------------------------------------------------------

  // stalls of random length at random points, none in steady phases
  initial begin
    int stall;
    stall       = 0;
    out_b.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (steady) begin
        out_b.ready <= 1'b1;
      end else if (stall > 0) begin
        out_b.ready <= 1'b0;
        stall--;
      end else if ($urandom_range(0, 4) == 0) begin
        stall = $urandom_range(1, 20);
        out_b.ready <= 1'b0;
      end else begin
        out_b.ready <= 1'b1;
      end
    end
  end

  // ---- main sequence -------------------------------------------------------

  initial begin
    int phase;
    int kind;
    int wait_cnt;
    rst_n             = 1'b0;
    in_b.valid        = 1'b0;
    in_b.operation    = OP_INSERT;
    in_b.time_req     = '0;
    in_b.sample_byte  = '0;
    in_b.volume       = '0;
    cfg_b.valid       = 1'b0;
    cfg_b.interp_mode = MODE_HOLD;
    burst_left        = 0;
    steady            = 1'b0;
    items_sent        = 0;
    fills_done        = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // hold mode out of reset: only the dummy entry, at both time extremes
    query_at('0);
    query_at(T_MAX);
    insert_at(48'd100, 8'sh80, 7'd64);     // most negative product
    insert_at(48'd200, 8'sh7f, 7'd127);    // volume saturates, largest product
    insert_at(48'd300, 8'sh01, 7'd0);      // zero volume
    query_at(48'd150);

    // nearest: tie goes to the newer sample, then the older wins, then a
    // query that lies before the oldest key
    set_mode(MODE_NEAREST);
    query_at(48'd250);
    query_at(48'd240);
    query_at(48'd150);

    // linear: midpoint, negative slope with truncation, query on a key,
    // a span across almost the full time range, then a single entry left
    set_mode(MODE_LINEAR);
    insert_at(48'd1300, 8'sh80, 7'd64);
    query_at(48'd250);
    query_at(48'd310);
    insert_at(48'd1301, 8'sd100, 7'd33);
    query_at(48'd1300);
    insert_at(T_MAX, -8'sd5, 7'd3);
    query_at(T_MAX - 1);
    query_at(T_MAX);

    // unused mode code with timestamps going backwards
    set_mode(MODE_ALT_HOLD);
    insert_at(48'd5, 8'sd7, 7'd64);
    insert_at(48'd3, -8'sd1, 7'd1);
    query_at(48'd4);
    query_at(48'd10);
    insert_at(48'd20, 8'sd50, 7'd2);
    query_at(48'd10);

    last_ins_t = 48'd20;
    last_q_t   = 48'd10;

    // random phases, the first four walk through every mode code
    phase = 0;
    while (items_sent < N_ITEMS) begin
      set_mode(mode_by_index((phase < 4) ? phase : $urandom_range(0, 3)));
      steady = ($urandom_range(0, 4) == 0);
      kind   = $urandom_range(0, 19);
      if (kind == 0 && fills_done < 3) begin
        // fill the store past its depth, then walk through it
        fills_done++;
        repeat ($urandom_range(STORE_DEPTH, STORE_DEPTH + 24)) begin
          last_ins_t = last_ins_t + TIME_W'($urandom_range(0, 50));
          insert_at(last_ins_t, SMP_W'($urandom), rand_volume());
        end
        repeat ($urandom_range(4, 12)) query_next();
      end else if (kind < 4) begin
        // noise: any field, any value
        repeat ($urandom_range(5, 30)) begin
          send_item(1'($urandom), rand_t(), SMP_W'($urandom), VOL_W'($urandom));
        end
      end else begin
        repeat ($urandom_range(20, 120)) begin
          if ($urandom_range(0, 1) == 0) insert_next();
          else query_next();
        end
      end
      phase++;
    end

    // drain: wait for every sample, then a query's latency more
    in_b.valid <= 1'b0;
    steady = 1'b0;
    wait_cnt = 0;
    while (pending != 0 && wait_cnt < 20000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (50) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // hang guard, several times the slowest expected run
  initial begin
    #6000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/tsi_pkg.sv
sv/tsi_if.sv
sv/tsi_div.sv
sv/tsi_datapath.sv
sv/tsi_ctrl.sv
sv/timestamped_sample_interpolator_top.sv
sim/tsi_lookup_checker.sv
sim/tb.sv
